### rtl/tsfla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed slot allocator package
// Shared constants, codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tsfla_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int NUM_TYPES = 6;

  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int TYPE_W    = 3;
  localparam int TIDX_W    = $clog2(NUM_TYPES);
  localparam int MEM_AW    = TIDX_W + SLOT_W;
  localparam int MEM_DEPTH = NUM_TYPES * MAX_SLOTS;
  localparam int CFG_AW    = 3;
  localparam int STAT_W    = 2;

  // Operation codes on the cmd port.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLOTS   = 2'd1;
  localparam logic [STAT_W-1:0] ST_STACK_FULL = 2'd2;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_FRESH,
    SRC_STACK
  } slot_src_t;

  // Controller to datapath.
  typedef struct packed {
    logic              load;
    logic              push;
    logic              pop;
    logic              bump;
    logic              reply;
    slot_src_t         src;
    logic [STAT_W-1:0] stat;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_free;
    logic stack_empty;
    logic stack_full;
    logic at_limit;
  } dp_stat_t;

endpackage

### rtl/tsfla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed slot allocator controller
// Sequences one transaction: accept, update the selected type, reply.
// ----------------------------------------------------------------------------
module tsfla_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tsfla_pkg::dp_stat_t dp_stat,
  output tsfla_pkg::ctl_cmd_t ctl,
  output logic               busy
);
  import tsfla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_REPLY
  } state_t;

  state_t            state;
  slot_src_t         src;
  logic [STAT_W-1:0] stat;
  slot_src_t         src_next;
  logic [STAT_W-1:0] stat_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    src_next  = SRC_ZERO;
    stat_next = ST_OK;
    ctl       = '0;
    ctl.src   = src;
    ctl.stat  = stat;
    case (state)
      S_IDLE: begin
        ctl.load = start;
      end
      S_DECIDE: begin
        if (dp_stat.is_free) begin
          if (dp_stat.stack_full) begin
            stat_next = ST_STACK_FULL;
          end else begin
            ctl.push = 1'b1;
          end
        end else if (!dp_stat.stack_empty) begin
          ctl.pop  = 1'b1;
          src_next = SRC_STACK;
        end else if (dp_stat.at_limit) begin
          stat_next = ST_NO_SLOTS;
        end else begin
          ctl.bump = 1'b1;
          src_next = SRC_FRESH;
        end
      end
      S_REPLY: begin
        ctl.reply = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      src   <= SRC_ZERO;
      stat  <= ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) state <= S_DECIDE;
        end
        S_DECIDE: begin
          src   <= src_next;
          stat  <= stat_next;
          state <= S_REPLY;
        end
        S_REPLY: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/tsfla_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed slot allocator datapath
// Limit registers, per-type stack depth and bump pointers, stack memory
// and the result registers.
// ----------------------------------------------------------------------------
module tsfla_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  tsfla_pkg::ctl_cmd_t            ctl,
  output tsfla_pkg::dp_stat_t            dp_stat,
  input  logic                           cfg_we,
  input  logic [tsfla_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [tsfla_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                           cmd,
  input  logic [tsfla_pkg::TYPE_W-1:0]   res_type,
  input  logic [tsfla_pkg::SLOT_W-1:0]   slot_in,
  output logic                           done,
  output logic [tsfla_pkg::SLOT_W-1:0]   slot_out,
  output logic [tsfla_pkg::STAT_W-1:0]   status,
  output logic [tsfla_pkg::CNT_W-1:0]    live_count
);
  import tsfla_pkg::*;

  logic [CNT_W-1:0]  limit_reg [NUM_TYPES];
  logic [CNT_W-1:0]  depth     [NUM_TYPES];
  logic [CNT_W-1:0]  fresh     [NUM_TYPES];
  logic [SLOT_W-1:0] stack_mem [MEM_DEPTH];

  logic              cmd_q;
  logic [TIDX_W-1:0] type_q;
  logic [SLOT_W-1:0] slot_in_q;
  logic [SLOT_W-1:0] fresh_slot;
  logic [SLOT_W-1:0] rd_data;

  logic [TIDX_W-1:0] type_sel;
  logic [CNT_W-1:0]  cur_depth;
  logic [CNT_W-1:0]  cur_fresh;
  logic [CNT_W-1:0]  cur_limit;
  logic [CNT_W-1:0]  depth_dec;
  logic [MEM_AW-1:0] push_addr;
  logic [MEM_AW-1:0] pop_addr;

  // Unknown types fold onto type 0.
  always_comb begin
    if (res_type < TYPE_W'(NUM_TYPES)) type_sel = res_type[TIDX_W-1:0];
    else                               type_sel = '0;
  end

  assign cur_depth = depth[type_q];
  assign cur_fresh = fresh[type_q];
  assign depth_dec = cur_depth - CNT_W'(1);
  assign push_addr = {type_q, cur_depth[SLOT_W-1:0]};
  assign pop_addr  = {type_q, depth_dec[SLOT_W-1:0]};

  // A limit programmed above the capacity behaves as the capacity.
  always_comb begin
    if (limit_reg[type_q] > CNT_W'(MAX_SLOTS)) cur_limit = CNT_W'(MAX_SLOTS);
    else                                       cur_limit = limit_reg[type_q];
  end

  assign dp_stat.is_free     = (cmd_q == CMD_FREE);
  assign dp_stat.stack_empty = (cur_depth == '0);
  assign dp_stat.stack_full  = (cur_depth >= CNT_W'(MAX_SLOTS));
  assign dp_stat.at_limit    = (cur_fresh >= cur_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        limit_reg[i] <= CNT_W'(MAX_SLOTS);
      end
    end else if (cfg_we && (cfg_addr < CFG_AW'(NUM_TYPES))) begin
      limit_reg[cfg_addr[TIDX_W-1:0]] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        depth[i] <= '0;
        fresh[i] <= '0;
      end
    end else begin
      if (ctl.push) depth[type_q] <= cur_depth + CNT_W'(1);
      if (ctl.pop)  depth[type_q] <= depth_dec;
      if (ctl.bump) fresh[type_q] <= cur_fresh + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q     <= cmd;
      type_q    <= type_sel;
      slot_in_q <= slot_in;
    end
    if (ctl.bump) fresh_slot <= cur_fresh[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.push) stack_mem[push_addr] <= slot_in_q;
    if (ctl.pop)  rd_data <= stack_mem[pop_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.reply;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.reply) begin
      status <= ctl.stat;
      case (ctl.src)
        SRC_FRESH: slot_out <= fresh_slot;
        SRC_STACK: slot_out <= rd_data;
        default:   slot_out <= '0;
      endcase
      // Unchecked frees can push the depth past the bump pointer.
      if (cur_fresh > cur_depth) live_count <= cur_fresh - cur_depth;
      else                       live_count <= '0;
    end
  end

endmodule

### rtl/typed_slot_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed slot free-list allocator
// Per-type LIFO free stacks backed by a bump pointer with a programmable
// limit.
// ----------------------------------------------------------------------------
// Usage:
//   Commands are issued on start with cmd, res_type and slot_in; one is
//   taken at a clock edge where start is high and busy is low. Every command
//   produces one result on slot_out, status and live_count, valid for the
//   single cycle in which done is high. The receiver cannot stall results.
//   A new command is not taken while one is in flight. The command is
//   latched when it is taken, the type's stack or bump pointer is then
//   updated (and the stack memory read launched on a pop), and the result
//   is then formed from the registered read data.
//   busy drops in the cycle done is shown, so the next command may be
//   accepted then.
//   Limits are written through cfg_we, cfg_addr and cfg_wdata while idle;
//   indexes above 5 are ignored. Reset sets every limit to 1024 and empties
//   every stack and bump pointer; no clearing pass runs, since only stack
//   entries below the current depth are ever read.
// ----------------------------------------------------------------------------
module typed_slot_free_list_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd,
  input  logic [tsfla_pkg::TYPE_W-1:0] res_type,
  input  logic [tsfla_pkg::SLOT_W-1:0] slot_in,
  output logic                         done,
  output logic [tsfla_pkg::SLOT_W-1:0] slot_out,
  output logic [tsfla_pkg::STAT_W-1:0] status,
  output logic [tsfla_pkg::CNT_W-1:0]  live_count,
  input  logic                         cfg_we,
  input  logic [tsfla_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tsfla_pkg::CNT_W-1:0]  cfg_wdata
);
  import tsfla_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t dp_stat;

  tsfla_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .dp_stat (dp_stat),
    .ctl     (ctl),
    .busy    (busy)
  );

  tsfla_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .dp_stat    (dp_stat),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .res_type   (res_type),
    .slot_in    (slot_in),
    .done       (done),
    .slot_out   (slot_out),
    .status     (status),
    .live_count (live_count)
  );

endmodule

### rtl/tsfla_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed slot allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tsfla_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [tsfla_pkg::SLOT_W-1:0] slot_out,
  input logic [tsfla_pkg::STAT_W-1:0] status,
  input logic [tsfla_pkg::CNT_W-1:0]  live_count
);
  import tsfla_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back results");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NO_SLOTS || status == ST_STACK_FULL))
    else $error("unknown status code");

  a_error_slot_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> slot_out == '0)
    else $error("failed transaction returned a nonzero slot");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> live_count <= CNT_W'(MAX_SLOTS))
    else $error("live count above capacity");

endmodule

bind typed_slot_free_list_allocator tsfla_checker u_tsfla_checker (.*);

### verif/typed_slot_free_list_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed slot free-list allocator testbench
// Sends allocate and free commands across all six resource types and the two
// unknown type codes. A behavioral copy of the per-type free stacks, bump
// pointers and limits predicts every result, and each result is checked
// field by field as it appears. Directed tests cover limits, exhaustion of a
// bump pointer, a full free stack and saturation of the live count. Random
// traffic then runs under several limit settings.
// ----------------------------------------------------------------------------
module typed_slot_free_list_allocator_tb;
  import tsfla_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_LIMIT  = 200;
  localparam int SETTLE_WAIT  = 4;

  // Limit register indexes. The two top indexes decode to nothing.
  localparam logic [CFG_AW-1:0] REG_MAX_SAMPLED_IMAGES   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_STORAGE_IMAGES   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_UNIFORM_BUFFERS  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_STORAGE_BUFFERS  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MAX_SAMPLERS         = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MAX_ACCEL_STRUCTURES = 3'd5;
  localparam logic [CFG_AW-1:0] REG_UNUSED_6             = 3'd6;
  localparam logic [CFG_AW-1:0] REG_UNUSED_7             = 3'd7;

  // Resource type codes on res_type; the last two fall back to type 0.
  localparam logic [TYPE_W-1:0] RT_SAMPLED_IMAGE   = 3'd0;
  localparam logic [TYPE_W-1:0] RT_STORAGE_IMAGE   = 3'd1;
  localparam logic [TYPE_W-1:0] RT_UNIFORM_BUFFER  = 3'd2;
  localparam logic [TYPE_W-1:0] RT_STORAGE_BUFFER  = 3'd3;
  localparam logic [TYPE_W-1:0] RT_SAMPLER         = 3'd4;
  localparam logic [TYPE_W-1:0] RT_ACCEL_STRUCTURE = 3'd5;
  localparam logic [TYPE_W-1:0] RT_UNKNOWN_6       = 3'd6;
  localparam logic [TYPE_W-1:0] RT_UNKNOWN_7       = 3'd7;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] LIMIT_TOP   = 11'd2047;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] stat;
    logic [CNT_W-1:0]  live;
  } alloc_result_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              cmd;
  logic [TYPE_W-1:0] res_type;
  logic [SLOT_W-1:0] slot_in;
  logic              done;
  logic [SLOT_W-1:0] slot_out;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  live_count;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CNT_W-1:0]  cfg_wdata;

  // Predicted allocator state.
  logic [SLOT_W-1:0] freed_slots [NUM_TYPES][MAX_SLOTS];
  int unsigned       stack_fill  [NUM_TYPES];
  int unsigned       bump_ptr    [NUM_TYPES];
  int unsigned       type_limit  [NUM_TYPES];

  alloc_result_t     pending_results[$];
  int                handed_type[$];
  logic [SLOT_W-1:0] handed_slot[$];

  bit          idle_enable = 1'b1;
  int          error_count = 0;
  int unsigned cycle_count = 0;

  typed_slot_free_list_allocator u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .res_type   (res_type),
    .slot_in    (slot_in),
    .done       (done),
    .slot_out   (slot_out),
    .status     (status),
    .live_count (live_count),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Applies one command to the predicted state and returns its result.
  function automatic alloc_result_t predict_allocator(logic op, logic [TYPE_W-1:0] rt,
                                                      logic [SLOT_W-1:0] idx);
    int            t;
    int unsigned   lim;
    alloc_result_t r;
    t = (rt < NUM_TYPES) ? int'(rt) : 0;
    r = '0;
    r.stat = ST_OK;
    lim = (type_limit[t] > MAX_SLOTS) ? MAX_SLOTS : type_limit[t];
    if (op == CMD_ALLOC) begin
      if (stack_fill[t] > 0) begin
        stack_fill[t] = stack_fill[t] - 1;
        r.slot = freed_slots[t][stack_fill[t]];
      end else if (bump_ptr[t] >= lim) begin
        r.stat = ST_NO_SLOTS;
      end else begin
        r.slot = SLOT_W'(bump_ptr[t]);
        bump_ptr[t] = bump_ptr[t] + 1;
      end
    end else begin
      if (stack_fill[t] >= MAX_SLOTS) begin
        r.stat = ST_STACK_FULL;
      end else begin
        freed_slots[t][stack_fill[t]] = idx;
        stack_fill[t] = stack_fill[t] + 1;
      end
    end
    // Unchecked frees can push the stack past the bump pointer; the count floors at zero.
    r.live = (bump_ptr[t] > stack_fill[t]) ? CNT_W'(bump_ptr[t] - stack_fill[t]) : '0;
    if (op == CMD_ALLOC && r.stat == ST_OK) begin
      handed_type = {handed_type, t};
      handed_slot = {handed_slot, r.slot};
    end
    return r;
  endfunction

  // Called just after a rising edge; returns just after the accepting edge, or after a random idle gap with start low.
  task automatic issue_command(input logic op, input logic [TYPE_W-1:0] rt,
                               input logic [SLOT_W-1:0] idx);
    start    <= 1'b1;
    cmd      <= op;
    res_type <= rt;
    slot_in  <= idx;
    do @(posedge clk); while (busy);
    pending_results = {pending_results, predict_allocator(op, rt, idx)};
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic settle_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // The trailing wait keeps the enable from being driven twice at one edge
  // when writes follow each other.
  task automatic write_limit(input logic [CFG_AW-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_TYPES) type_limit[idx] = val;
    @(posedge clk);
  endtask

  // Random limits with the range ends picked often.
  task automatic program_limits(input int unsigned lo, input int unsigned hi);
    int i;
    int unsigned val;
    for (i = 0; i < NUM_TYPES; i++) begin
      case ($urandom_range(0, 3))
        0: val = lo;
        1: val = hi;
        default: val = $urandom_range(lo, hi);
      endcase
      write_limit(CFG_AW'(i), CNT_W'(val));
    end
  endtask

  // Mostly well-formed traffic: frees usually return a slot that was handed out.
  task automatic random_command();
    logic              op;
    logic [TYPE_W-1:0] rt;
    logic [SLOT_W-1:0] idx;
    int                k;
    op = ($urandom_range(0, 99) < 55) ? CMD_ALLOC : CMD_FREE;
    if ($urandom_range(0, 9) == 0) rt = TYPE_W'($urandom_range(NUM_TYPES, 7));
    else rt = TYPE_W'($urandom_range(0, NUM_TYPES - 1));
    idx = SLOT_W'($urandom);
    if (op == CMD_FREE && handed_slot.size() != 0 && $urandom_range(0, 3) != 0) begin
      k   = $urandom_range(0, handed_slot.size() - 1);
      rt  = TYPE_W'(handed_type[k]);
      idx = handed_slot[k];
      handed_type.delete(k);
      handed_slot.delete(k);
    end
    issue_command(op, rt, idx);
  endtask

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: slot_out %0d status %0d live_count %0d",
               slot_out, status, live_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (slot_out !== want.slot) begin
          $error("slot_out mismatch: expected %0d, got %0d", want.slot, slot_out);
          error_count++;
        end
        if (status !== want.stat) begin
          $error("status mismatch: expected %0d, got %0d", want.stat, status);
          error_count++;
        end
        if (live_count !== want.live) begin
          $error("live_count mismatch: expected %0d, got %0d", want.live, live_count);
          error_count++;
        end
      end
    end
  end

  task automatic test_alloc_free_basics();
    int i;
    for (i = 0; i < 8; i++) issue_command(CMD_ALLOC, TYPE_W'(i), SLOT_W'($urandom));
    issue_command(CMD_FREE, RT_UNIFORM_BUFFER, '1);
    issue_command(CMD_FREE, RT_UNIFORM_BUFFER, '0);
    // Last in, first out: zero comes back before all ones.
    issue_command(CMD_ALLOC, RT_UNIFORM_BUFFER, '1);
    issue_command(CMD_ALLOC, RT_UNIFORM_BUFFER, '0);
    issue_command(CMD_FREE, RT_UNKNOWN_6, 10'h2AA);
    issue_command(CMD_FREE, RT_UNKNOWN_7, 10'h155);
    issue_command(CMD_ALLOC, RT_SAMPLED_IMAGE, '0);
    settle_idle();
  endtask

  task automatic test_limit_registers();
    write_limit(REG_MAX_SAMPLED_IMAGES, '0);
    write_limit(REG_MAX_STORAGE_IMAGES, 11'd2);
    write_limit(REG_MAX_UNIFORM_BUFFERS, LIMIT_TOP);
    write_limit(REG_MAX_STORAGE_BUFFERS, 11'd1025);
    write_limit(REG_MAX_SAMPLERS, 11'd1);
    write_limit(REG_MAX_ACCEL_STRUCTURES, 11'd3);
    // Writes to unused indexes must not alias onto a real limit.
    write_limit(REG_UNUSED_6, '0);
    write_limit(REG_UNUSED_7, '0);
    repeat (3) issue_command(CMD_ALLOC, RT_SAMPLED_IMAGE, '1);
    repeat (2) issue_command(CMD_ALLOC, RT_STORAGE_IMAGE, '0);
    issue_command(CMD_ALLOC, RT_SAMPLER, '0);
    repeat (3) issue_command(CMD_FREE, RT_SAMPLER, SLOT_W'($urandom));
    issue_command(CMD_ALLOC, RT_SAMPLER, '0);
    issue_command(CMD_ALLOC, RT_UNIFORM_BUFFER, '0);
    repeat (4) issue_command(CMD_ALLOC, RT_ACCEL_STRUCTURE, '0);
    settle_idle();
  endtask

  // Limit 1025 acts as full capacity, so the pointer runs out at MAX_SLOTS.
  task automatic test_bump_exhaustion();
    while (stack_fill[RT_STORAGE_BUFFER] > 0 || bump_ptr[RT_STORAGE_BUFFER] < MAX_SLOTS)
      issue_command(CMD_ALLOC, RT_STORAGE_BUFFER, SLOT_W'($urandom));
    repeat (2) issue_command(CMD_ALLOC, RT_STORAGE_BUFFER, '0);
    settle_idle();
  endtask

  task automatic test_stack_full();
    while (stack_fill[RT_ACCEL_STRUCTURE] < MAX_SLOTS)
      issue_command(CMD_FREE, RT_ACCEL_STRUCTURE, SLOT_W'($urandom));
    repeat (2) issue_command(CMD_FREE, RT_ACCEL_STRUCTURE, '1);
    repeat (3) issue_command(CMD_ALLOC, RT_ACCEL_STRUCTURE, '0);
    issue_command(CMD_FREE, RT_ACCEL_STRUCTURE, '0);
    settle_idle();
  endtask

  task automatic test_random_traffic(input int count, input int unsigned lo,
                                     input int unsigned hi);
    program_limits(lo, hi);
    repeat (count) random_command();
    settle_idle();
  endtask

  initial begin : run_tests
    int i;
    int waited;
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = CMD_ALLOC;
    res_type  = '0;
    slot_in   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    for (i = 0; i < NUM_TYPES; i++) begin
      type_limit[i] = LIMIT_RESET;
      stack_fill[i] = 0;
      bump_ptr[i]   = 0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_alloc_free_basics();
    test_limit_registers();
    test_bump_exhaustion();
    test_stack_full();
    test_random_traffic(300, 0, 12);
    test_random_traffic(300, 0, LIMIT_TOP);
    idle_enable = 1'b0;
    test_random_traffic(400, 0, LIMIT_RESET);

    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
